// ===== hw/rtl/scrypt_romix_salsa20_8_unit_assert.svh =====
// assertion macros for the scrypt romix unit
// used by the port checker only
`ifndef SCRYPT_ROMIX_SALSA20_8_UNIT_ASSERT_SVH
`define SCRYPT_ROMIX_SALSA20_8_UNIT_ASSERT_SVH
`define SR_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define SR_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/srx_pkg.sv =====
// shared types and constants for the scrypt romix unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package srx_pkg;
    localparam int BLOCK_R_DEF   = 1;
    localparam int MAX_LOG_N_DEF = 10;
    localparam logic [3:0] LOG_N_RESET = 4'd10;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // one double round of salsa20 on sixteen 32-bit words
    function automatic logic [511:0] double_round(input logic [511:0] s);
        logic [31:0] x [16];
        for (int i = 0; i < 16; i++)
        begin
            x[i] = s[32*i +: 32];
        end
        x[4]  ^= rotl(x[0]  + x[12], 7);  x[8]  ^= rotl(x[4]  + x[0],  9);
        x[12] ^= rotl(x[8]  + x[4], 13);  x[0]  ^= rotl(x[12] + x[8], 18);
        x[9]  ^= rotl(x[5]  + x[1],  7);  x[13] ^= rotl(x[9]  + x[5],  9);
        x[1]  ^= rotl(x[13] + x[9], 13);  x[5]  ^= rotl(x[1]  + x[13], 18);
        x[14] ^= rotl(x[10] + x[6],  7);  x[2]  ^= rotl(x[14] + x[10], 9);
        x[6]  ^= rotl(x[2]  + x[14], 13); x[10] ^= rotl(x[6]  + x[2], 18);
        x[3]  ^= rotl(x[15] + x[11], 7);  x[7]  ^= rotl(x[3]  + x[15], 9);
        x[11] ^= rotl(x[7]  + x[3], 13);  x[15] ^= rotl(x[11] + x[7], 18);
        x[1]  ^= rotl(x[0]  + x[3],  7);  x[2]  ^= rotl(x[1]  + x[0],  9);
        x[3]  ^= rotl(x[2]  + x[1], 13);  x[0]  ^= rotl(x[3]  + x[2], 18);
        x[6]  ^= rotl(x[5]  + x[4],  7);  x[7]  ^= rotl(x[6]  + x[5],  9);
        x[4]  ^= rotl(x[7]  + x[6], 13);  x[5]  ^= rotl(x[4]  + x[7], 18);
        x[11] ^= rotl(x[10] + x[9],  7);  x[8]  ^= rotl(x[11] + x[10], 9);
        x[9]  ^= rotl(x[8]  + x[11], 13); x[10] ^= rotl(x[9]  + x[8], 18);
        x[12] ^= rotl(x[15] + x[14], 7);  x[13] ^= rotl(x[12] + x[15], 9);
        x[14] ^= rotl(x[13] + x[12], 13); x[15] ^= rotl(x[14] + x[13], 18);
        for (int i = 0; i < 16; i++)
        begin
            double_round[32*i +: 32] = x[i];
        end
    endfunction

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_RD    = 7'b0000010,
        ST_XOR   = 7'b0000100,
        ST_CORE  = 7'b0001000,
        ST_FIN   = 7'b0010000,
        ST_WB    = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/srx_core.sv =====
// salsa20/8 core: four double rounds, one per cycle, then feed-forward add
// depends on srx_pkg
`timescale 1ns / 1ps
`default_nettype none
module srx_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [511:0] din,
    output logic              done,
    output logic [511:0]      dout
);
    import srx_pkg::*;
    logic [511:0] init_reg, x_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 3'd0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd3)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            init_reg <= din;
            x_reg    <= din;
        end
        else if (busy_reg)
            x_reg <= double_round(x_reg);
    end

    assign done = busy_reg && (cnt_reg == 3'd3);
    always_comb
    begin
        logic [511:0] f;
        f = double_round(x_reg);
        for (int i = 0; i < 16; i++)
        begin
            dout[32*i +: 32] = f[32*i +: 32] + init_reg[32*i +: 32];
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/scrypt_romix_salsa20_8_unit.sv =====
// top level of the scrypt romix unit: sequencer, work and vector memories
// depends on srx_pkg and srx_core
`timescale 1ns / 1ps
`default_nettype none
// Takes 16*BLOCK_R words of one block, runs ROMix with N = 2^log_n, log_n
// clamped to 1..MAX_LOG_N, and returns 16*BLOCK_R words, last_word marking the
// final one. One block is in work at a time; the input stays stalled from the
// last loaded word until the last result transfer. Each BlockMix first reads the
// last sub-block into the accumulator, then per sub-block takes a setup step,
// reads and folds 8 words, runs salsa20/8 and stores the scratch copy, then
// writes the block back. A block takes 2N BlockMix calls.
// The vector memory is read one word per cycle beside the work memory.
module scrypt_romix_salsa20_8_unit #(
    parameter int BLOCK_R   = srx_pkg::BLOCK_R_DEF,
    parameter int MAX_LOG_N = srx_pkg::MAX_LOG_N_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        block_valid,
    output logic             block_ready,
    input  wire logic [63:0] block_word,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [63:0]      result_word,
    output logic             last_word
);
    import srx_pkg::*;
    localparam int BW  = 16 * BLOCK_R;
    localparam int WA  = $clog2(BW);
    localparam int SUB = 2 * BLOCK_R;
    localparam int SA  = (SUB > 1) ? $clog2(SUB) : 1;
    localparam int VA  = MAX_LOG_N + WA;
    localparam int RW  = MAX_LOG_N + 1;

    logic [3:0] log_n_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {28'd0, log_n_reg} : 32'd0;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            log_n_reg <= LOG_N_RESET;
        else if (psel && penable && pwrite && paddr == 2'd0)
            log_n_reg <= pwdata[3:0];
    end

    logic [63:0] work_mem [BW];
    logic [63:0] scr_mem [BW];
    logic [63:0] vec_mem [2**VA];

    state_t       state_reg;
    logic [WA:0]  cnt_reg;      // word counter inside a sub-block or block
    logic [SA-1:0] sub_reg;
    logic          phase_reg;   // 0 fill, 1 random rounds
    logic          seed_reg;    // reading the last sub-block into the accumulator
    logic [RW-1:0] round_reg;
    logic [RW-1:0] n_reg;
    logic [MAX_LOG_N-1:0] idx_reg;
    logic [511:0]  acc_reg;
    logic          out_pend_reg;
    logic          core_go_reg;

    logic          core_done;
    logic [511:0]  core_out;
    srx_core u_core (.clk(clk), .rst_n(rst_n), .start(core_go_reg), .din(acc_reg),
        .done(core_done), .dout(core_out));

    // memory read ports, registered data
    logic [WA-1:0] wrd_addr;
    logic [63:0]   wrd_reg, vrd_reg, srd_reg;
    logic [VA-1:0] vrd_addr;
    logic          rd_v_reg;    // read data of last cycle is valid
    logic [WA-1:0] rd_w_reg;

    logic [RW-1:0] ln_sat;
    always_comb
    begin
        logic [3:0] l;
        l = log_n_reg;
        if (l == 4'd0) l = 4'd1;
        if (int'(l) > MAX_LOG_N) l = 4'(MAX_LOG_N);
        ln_sat = RW'(1) << l;
    end

    // rd address: XOR reads word cnt of sub-block (last if seeding); OUT of block
    always_comb
    begin
        wrd_addr = WA'(cnt_reg[WA-1:0]);
        if (state_reg == ST_RD || state_reg == ST_XOR)
        begin
            if (seed_reg)
                wrd_addr = WA'({SA'(SUB - 1), 3'b000}) + WA'(cnt_reg[2:0]);
            else
                wrd_addr = WA'({sub_reg, 3'b000}) + WA'(cnt_reg[2:0]);
        end
        vrd_addr = {idx_reg, wrd_addr};
    end

    always_ff @(posedge clk)
    begin
        wrd_reg <= work_mem[wrd_addr];
        vrd_reg <= vec_mem[vrd_addr];
        srd_reg <= scr_mem[cnt_reg[WA-1:0]];
    end

    logic out_fire;
    assign out_fire = result_valid && result_ready;
    assign block_ready = (state_reg == ST_LOAD) && !out_pend_reg;

    // writeback: reorder even sub-blocks to front, odd to back
    logic [WA-1:0] wb_dst;
    always_comb
    begin
        logic [SA-1:0] s;
        s = rd_w_reg[WA-1:3];
        if (s[0] == 1'b0)
            wb_dst = WA'({SA'(s >> 1), 3'b000}) + WA'(rd_w_reg[2:0]);
        else
            wb_dst = WA'({SA'(BLOCK_R) + SA'(s >> 1), 3'b000}) + WA'(rd_w_reg[2:0]);
    end

    logic [63:0] xin;
    assign xin = wrd_reg ^ (phase_reg ? vrd_reg : 64'd0);

    always_ff @(posedge clk)
    begin
        if (block_valid && block_ready)
            work_mem[cnt_reg[WA-1:0]] <= block_word;
        if (state_reg == ST_XOR && rd_v_reg && !seed_reg)
        begin
            if (!phase_reg)
                vec_mem[{round_reg[MAX_LOG_N-1:0], rd_w_reg}] <= wrd_reg;
            else
                work_mem[rd_w_reg] <= xin;
        end
        if (state_reg == ST_FIN)
            for (int i = 0; i < 8; i++)
                scr_mem[WA'({sub_reg, 3'b000}) + WA'(i)] <= acc_reg[64*i +: 64];
        if (state_reg == ST_WB && rd_v_reg)
            work_mem[wb_dst] <= srd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            cnt_reg      <= '0;
            sub_reg      <= '0;
            phase_reg    <= 1'b0;
            seed_reg     <= 1'b0;
            round_reg    <= '0;
            n_reg        <= '0;
            idx_reg      <= '0;
            rd_v_reg     <= 1'b0;
            rd_w_reg     <= '0;
            out_pend_reg <= 1'b0;
            core_go_reg  <= 1'b0;
            result_valid <= 1'b0;
            last_word    <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            rd_v_reg    <= 1'b0;
            core_go_reg <= 1'b0;
            rd_w_reg    <= wrd_addr;
            case (state_reg)
                ST_LOAD:
                begin
                    if (block_valid && block_ready)
                    begin
                        if (cnt_reg[WA-1:0] == WA'(BW - 1))
                        begin
                            cnt_reg   <= '0;
                            sub_reg   <= '0;
                            phase_reg <= 1'b0;
                            seed_reg  <= 1'b1;
                            round_reg <= '0;
                            n_reg     <= ln_sat;
                            idx_reg   <= '0;
                            state_reg <= ST_RD;
                        end
                        else
                            cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_RD:
                begin
                    // seed accumulator with last sub-block: read it through XOR pass
                    cnt_reg   <= '0;
                    state_reg <= ST_XOR;
                    if (seed_reg)
                        acc_reg <= '0;
                end
                ST_XOR:
                begin
                    // read 8 words, fold into accumulator
                    if (cnt_reg < 8)
                    begin
                        cnt_reg  <= cnt_reg + 1'b1;
                        rd_v_reg <= 1'b1;
                    end
                    if (rd_v_reg)
                    begin
                        acc_reg[64*rd_w_reg[2:0] +: 64] <=
                            acc_reg[64*rd_w_reg[2:0] +: 64] ^ xin;
                        if (rd_w_reg[2:0] == 3'd7)
                        begin
                            if (seed_reg)
                            begin
                                seed_reg  <= 1'b0;
                                state_reg <= ST_RD;
                            end
                            else
                            begin
                                // start the core once the last word is folded in
                                core_go_reg <= 1'b1;
                                state_reg   <= ST_CORE;
                            end
                        end
                    end
                end
                ST_CORE:
                begin
                    if (core_done)
                    begin
                        acc_reg   <= core_out;
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (sub_reg == SA'(SUB - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_WB;
                    end
                    else
                    begin
                        sub_reg   <= sub_reg + 1'b1;
                        state_reg <= ST_RD;
                    end
                end
                ST_WB:
                begin
                    if (cnt_reg < BW)
                    begin
                        cnt_reg  <= cnt_reg + 1'b1;
                        rd_v_reg <= 1'b1;
                    end
                    if (rd_v_reg && rd_w_reg == WA'(BW - 1))
                    begin
                        cnt_reg <= '0;
                        sub_reg <= '0;
                        if (round_reg == n_reg - 1'b1)
                        begin
                            round_reg <= '0;
                            if (phase_reg)
                                state_reg <= ST_OUT;
                            else
                            begin
                                phase_reg <= 1'b1;
                                seed_reg  <= 1'b1;
                                idx_reg   <= acc_reg[MAX_LOG_N-1:0]
                                             & MAX_LOG_N'(n_reg - 1'b1);
                                state_reg <= ST_RD;
                            end
                        end
                        else
                        begin
                            round_reg <= round_reg + 1'b1;
                            seed_reg  <= 1'b1;
                            idx_reg   <= acc_reg[MAX_LOG_N-1:0] & MAX_LOG_N'(n_reg - 1'b1);
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_OUT:
                begin
                    // one word in flight through the read register
                    if (!result_valid || out_fire)
                    begin
                        if (cnt_reg < BW && !out_pend_reg)
                        begin
                            out_pend_reg <= 1'b1;
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                    if (out_pend_reg && (!result_valid || out_fire))
                    begin
                        out_pend_reg <= 1'b0;
                    end
                    if (out_fire && last_word)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_LOAD;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
            if (state_reg == ST_OUT && out_pend_reg && (!result_valid || out_fire))
            begin
                result_valid <= 1'b1;
                last_word    <= (rd_w_reg == WA'(BW - 1));
            end
            else if (out_fire)
                result_valid <= 1'b0;
        end
    end
    // last sub-block's first word is the first word of the final salsa output
    // (acc_reg holds that output during writeback)

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_pend_reg && (!result_valid || out_fire))
            result_word <= wrd_reg;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/srx_checker.sv =====
// port-level checker for the scrypt romix unit, bound to the top level
// depends on scrypt_romix_salsa20_8_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "scrypt_romix_salsa20_8_unit_assert.svh"
module srx_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        block_ready,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire logic [63:0] result_word,
    input wire logic        last_word,
    input wire logic        pready
);
    logic out_stall;
    logic last_fire;
    assign out_stall = result_valid && !result_ready;
    assign last_fire = result_valid && result_ready && last_word;

    `SR_ASSERT_IMP(a_no_load_while_out, clk, rst_n, result_valid, !block_ready)
    `SR_ASSERT_NEXT(a_hold, clk, rst_n, out_stall, result_valid && $stable(result_word))
    `SR_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, pready)
    `SR_ASSERT_NEXT(a_last_end, clk, rst_n, last_fire, !result_valid)
endmodule
bind scrypt_romix_salsa20_8_unit srx_checker u_chk (.clk(clk), .rst_n(rst_n),
    .block_ready(block_ready), .result_valid(result_valid),
    .result_ready(result_ready), .result_word(result_word),
    .last_word(last_word), .pready(pready));
`default_nettype wire
